>>> design/fca_pkg.sv
// Shared types and constants for the contiguous fit allocator.
// No dependencies; used by the core, the checker and the testbench.
package fca_pkg;

    // Fixed payload widths
    localparam int REQ_W    = 11;
    localparam int POS_W    = 6;
    localparam int START_W  = 10;
    localparam int COUNT_W  = 7;
    localparam int POLICY_W = 2;

    typedef enum logic [POLICY_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } fit_policy_t;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_MOD      = 11'b000_0000_0010,
        S_SCAN     = 11'b000_0000_0100,
        S_TAKE     = 11'b000_0000_1000,
        S_SHIFT_DN = 11'b000_0001_0000,
        S_USED_SH  = 11'b000_0010_0000,
        S_FIND     = 11'b000_0100_0000,
        S_MERGE    = 11'b000_1000_0000,
        S_SHIFT_UP = 11'b001_0000_0000,
        S_DONE     = 11'b010_0000_0000,
        S_SPARE    = 11'b100_0000_0000
    } state_t;

endpackage

>>> design/fca_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// No dependencies.
module fca_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 21
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/contiguous_fit_allocator_core.sv
// Top level of the contiguous fit allocator: sequencer, tables and handshakes.
// Depends on fca_pkg and fca_ram.
//
// One transaction in, one result out. The block holds a free table, kept in
// ascending address order, and an allocated table in allocation order, each
// in a synchronous RAM with one read and one write port. Items are handled
// one at a time: an allocation walks the free table (first and next fit stop
// at the first hit; next fit first reduces its start position modulo
// free_count), then closes a slot in the free table when an exact fit removes
// an entry. A release walks the allocated table from the position up and then
// the free table, and may open or close a slot in the free table. Each table
// walk issues one RAM read per cycle. No clearing pass is needed after reset.
// in_stall is low only while idle; a finished result sits in the output
// register, so the next transaction can be taken while the previous result
// waits. The user must write fit_policy only while the block is idle; the
// block itself does not enforce it. cfg_ready is always high.
module contiguous_fit_allocator_core #(
    parameter int MEM_UNITS  = 1024,
    parameter int MAX_BLOCKS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fca_pkg::POLICY_W-1:0]  fit_policy,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [fca_pkg::REQ_W-1:0]     alloc_units,
    input  logic [fca_pkg::POS_W-1:0]     release_position,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [fca_pkg::START_W-1:0]   block_start,
    output logic [fca_pkg::COUNT_W-1:0]   allocated_count
);

    localparam int AD_W = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
    localparam int SZ_W = $clog2(MEM_UNITS + 1);
    localparam int IX_W = $clog2(MAX_BLOCKS);
    localparam int CN_W = $clog2(MAX_BLOCKS + 1);
    localparam int CW   = (SZ_W > fca_pkg::REQ_W) ? SZ_W : fca_pkg::REQ_W;
    localparam int PW   = (CN_W > fca_pkg::POS_W) ? CN_W : fca_pkg::POS_W;
    localparam int EW   = AD_W + SZ_W;
    localparam logic [SZ_W-1:0] MEM_SIZE = SZ_W'(MEM_UNITS);
    localparam logic [CN_W-1:0] MAXB     = CN_W'(MAX_BLOCKS);

    // Control state
    fca_pkg::state_t      state_reg, state_next;
    fca_pkg::fit_policy_t policy_reg, policy_next;
    logic [CN_W-1:0]      fc_reg, fc_next;          // free entries
    logic [CN_W-1:0]      uc_reg, uc_next;          // allocated entries
    logic [CN_W-1:0]      nf_pos_reg, nf_pos_next;
    logic                 nf_empty_reg, nf_empty_next;
    logic                 e0_init_reg, e0_init_next; // free entry 0 written since reset
    logic                 dflt_reg, dflt_next;       // last read hit unwritten entry 0
    logic                 out_valid_reg, out_valid_next;

    // Walk pointers: issue pointer, issued count, limit, data-valid tag
    logic [CN_W-1:0]      ptr_reg, ptr_next;
    logic [CN_W-1:0]      cnt_reg, cnt_next;
    logic [CN_W-1:0]      lim_reg, lim_next;
    logic                 dv_reg, dv_next;
    logic [IX_W-1:0]      didx_reg, didx_next;

    // Transaction payload
    logic [fca_pkg::REQ_W-1:0] req_reg, req_next;
    logic [IX_W-1:0]      pos_reg, pos_next;
    logic                 found_reg, found_next;
    logic [IX_W-1:0]      pick_idx_reg, pick_idx_next;
    logic [AD_W-1:0]      pick_start_reg, pick_start_next;
    logic [SZ_W-1:0]      pick_size_reg, pick_size_next;
    logic [AD_W-1:0]      rel_start_reg, rel_start_next;
    logic [SZ_W-1:0]      rel_size_reg, rel_size_next;
    logic                 prev_vld_reg, prev_vld_next;
    logic [AD_W-1:0]      prev_start_reg, prev_start_next;
    logic [SZ_W-1:0]      prev_size_reg, prev_size_next;
    logic                 cur_vld_reg, cur_vld_next;
    logic [AD_W-1:0]      cur_start_reg, cur_start_next;
    logic [SZ_W-1:0]      cur_size_reg, cur_size_next;
    logic [CN_W-1:0]      p_reg, p_next;
    logic                 res_ok_reg, res_ok_next;
    logic [AD_W-1:0]      res_start_reg, res_start_next;
    logic                 ok_reg, ok_next;
    logic [fca_pkg::START_W-1:0] start_out_reg, start_out_next;
    logic [fca_pkg::COUNT_W-1:0] count_out_reg, count_out_next;

    // RAM ports
    logic            f_we, f_re, u_we, u_re;
    logic [IX_W-1:0] f_waddr, f_raddr, u_waddr, u_raddr;
    logic [EW-1:0]   f_wdata, f_rdata, u_wdata, u_rdata, fr;

    logic [AD_W-1:0] fr_start, ur_start;
    logic [SZ_W-1:0] fr_size, ur_size, req_sz;
    logic            fits, gone, left, right;
    logic [CN_W-1:0] fc_after, nf_v;

    fca_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(EW)) u_free_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .re    (f_re),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    fca_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(EW)) u_used_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .re    (u_re),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    // Free entry 0 reads as the whole memory until first written.
    assign fr       = dflt_reg ? {{AD_W{1'b0}}, MEM_SIZE} : f_rdata;
    assign fr_start = fr[EW-1:SZ_W];
    assign fr_size  = fr[SZ_W-1:0];
    assign ur_start = u_rdata[EW-1:SZ_W];
    assign ur_size  = u_rdata[SZ_W-1:0];
    assign req_sz   = SZ_W'(req_reg);
    assign fits     = CW'(fr_size) >= CW'(req_reg);
    assign gone     = CW'(pick_size_reg) == CW'(req_reg);
    assign fc_after = gone ? fc_reg - 1'b1 : fc_reg;
    assign nf_v     = gone ? CN_W'(pick_idx_reg) : CN_W'(pick_idx_reg) + 1'b1;

    // Neighbor tests for a release: left ends at the block, right starts after it
    assign left  = prev_vld_reg
                   && (SZ_W'(prev_start_reg) + prev_size_reg == SZ_W'(rel_start_reg));
    assign right = cur_vld_reg
                   && (SZ_W'(cur_start_reg) == SZ_W'(rel_start_reg) + rel_size_reg);

    assign cfg_ready       = 1'b1;
    assign in_stall        = (state_reg != fca_pkg::S_IDLE);
    assign out_valid       = out_valid_reg;
    assign ok              = ok_reg;
    assign block_start     = start_out_reg;
    assign allocated_count = count_out_reg;

    always_comb
    begin
        state_next      = state_reg;
        policy_next     = policy_reg;
        fc_next         = fc_reg;
        uc_next         = uc_reg;
        nf_pos_next     = nf_pos_reg;
        nf_empty_next   = nf_empty_reg;
        out_valid_next  = out_valid_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        lim_next        = lim_reg;
        dv_next         = 1'b0;
        didx_next       = didx_reg;
        req_next        = req_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;
        pick_idx_next   = pick_idx_reg;
        pick_start_next = pick_start_reg;
        pick_size_next  = pick_size_reg;
        rel_start_next  = rel_start_reg;
        rel_size_next   = rel_size_reg;
        prev_vld_next   = prev_vld_reg;
        prev_start_next = prev_start_reg;
        prev_size_next  = prev_size_reg;
        cur_vld_next    = cur_vld_reg;
        cur_start_next  = cur_start_reg;
        cur_size_next   = cur_size_reg;
        p_next          = p_reg;
        res_ok_next     = res_ok_reg;
        res_start_next  = res_start_reg;
        ok_next         = ok_reg;
        start_out_next  = start_out_reg;
        count_out_next  = count_out_reg;

        f_we    = 1'b0;
        f_waddr = '0;
        f_wdata = '0;
        f_re    = 1'b0;
        f_raddr = '0;
        u_we    = 1'b0;
        u_waddr = '0;
        u_wdata = '0;
        u_re    = 1'b0;
        u_raddr = '0;

        if (cfg_valid)
        begin
            policy_next = fca_pkg::fit_policy_t'(fit_policy);
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            fca_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    res_ok_next    = 1'b0;
                    res_start_next = '0;
                    req_next       = alloc_units;
                    if (mode == fca_pkg::MODE_RELEASE)
                    begin
                        if (PW'(release_position) >= PW'(uc_reg))
                        begin
                            state_next = fca_pkg::S_DONE;
                        end
                        else
                        begin
                            pos_next   = IX_W'(release_position);
                            ptr_next   = CN_W'(release_position);
                            state_next = fca_pkg::S_USED_SH;
                        end
                    end
                    else if (alloc_units == '0 || uc_reg >= MAXB || fc_reg == '0)
                    begin
                        state_next = fca_pkg::S_DONE;
                    end
                    else
                    begin
                        found_next = 1'b0;
                        cnt_next   = '0;
                        if (policy_reg == fca_pkg::FIT_NEXT && !nf_empty_reg)
                        begin
                            ptr_next   = nf_pos_reg;
                            state_next = fca_pkg::S_MOD;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            state_next = fca_pkg::S_SCAN;
                        end
                    end
                end
            end

            // Next fit start: remembered position mod free count
            fca_pkg::S_MOD:
            begin
                if (ptr_reg >= fc_reg)
                begin
                    ptr_next = ptr_reg - fc_reg;
                end
                else
                begin
                    state_next = fca_pkg::S_SCAN;
                end
            end

            fca_pkg::S_SCAN:
            begin
                if (cnt_reg < fc_reg)
                begin
                    f_re      = 1'b1;
                    f_raddr   = IX_W'(ptr_reg);
                    didx_next = IX_W'(ptr_reg);
                    dv_next   = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    ptr_next  = (ptr_reg + 1'b1 == fc_reg) ? '0 : ptr_reg + 1'b1;
                end
                if (dv_reg)
                begin
                    case (policy_reg) inside
                        fca_pkg::FIT_FIRST, fca_pkg::FIT_NEXT:
                        begin
                            if (fits)
                            begin
                                found_next      = 1'b1;
                                pick_idx_next   = didx_reg;
                                pick_start_next = fr_start;
                                pick_size_next  = fr_size;
                                state_next      = fca_pkg::S_TAKE;
                            end
                        end
                        fca_pkg::FIT_BEST:
                        begin
                            if (fits && (!found_reg || fr_size < pick_size_reg))
                            begin
                                found_next      = 1'b1;
                                pick_idx_next   = didx_reg;
                                pick_start_next = fr_start;
                                pick_size_next  = fr_size;
                            end
                        end
                        default:
                        begin
                            if (!found_reg || fr_size > pick_size_reg)
                            begin
                                found_next      = 1'b1;
                                pick_idx_next   = didx_reg;
                                pick_start_next = fr_start;
                                pick_size_next  = fr_size;
                            end
                        end
                    endcase
                end
                else if (cnt_reg >= fc_reg)
                begin
                    if (found_reg && CW'(pick_size_reg) >= CW'(req_reg))
                    begin
                        state_next = fca_pkg::S_TAKE;
                    end
                    else
                    begin
                        state_next = fca_pkg::S_DONE;
                    end
                end
            end

            fca_pkg::S_TAKE:
            begin
                u_we           = 1'b1;
                u_waddr        = IX_W'(uc_reg);
                u_wdata        = {pick_start_reg, req_sz};
                uc_next        = uc_reg + 1'b1;
                res_ok_next    = 1'b1;
                res_start_next = pick_start_reg;
                if (gone)
                begin
                    fc_next    = fc_reg - 1'b1;
                    ptr_next   = CN_W'(pick_idx_reg) + 1'b1;
                    lim_next   = fc_reg;
                    state_next = fca_pkg::S_SHIFT_DN;
                end
                else
                begin
                    f_we       = 1'b1;
                    f_waddr    = pick_idx_reg;
                    f_wdata    = {AD_W'(SZ_W'(pick_start_reg) + req_sz),
                                  pick_size_reg - req_sz};
                    state_next = fca_pkg::S_DONE;
                end
                if (policy_reg == fca_pkg::FIT_NEXT)
                begin
                    if (fc_after == '0)
                    begin
                        nf_empty_next = 1'b1;
                        nf_pos_next   = '0;
                    end
                    else
                    begin
                        nf_empty_next = 1'b0;
                        nf_pos_next   = (nf_v == fc_after) ? '0 : nf_v;
                    end
                end
            end

            // Close a slot: entry k+1 moves to k, one per cycle
            fca_pkg::S_SHIFT_DN:
            begin
                if (ptr_reg < lim_reg)
                begin
                    f_re      = 1'b1;
                    f_raddr   = IX_W'(ptr_reg);
                    didx_next = IX_W'(ptr_reg);
                    dv_next   = 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                end
                if (dv_reg)
                begin
                    f_we    = 1'b1;
                    f_waddr = didx_reg - 1'b1;
                    f_wdata = fr;
                end
                else if (ptr_reg >= lim_reg)
                begin
                    state_next = fca_pkg::S_DONE;
                end
            end

            // Release: fetch the block, then pull later allocated entries down
            fca_pkg::S_USED_SH:
            begin
                if (ptr_reg < uc_reg)
                begin
                    u_re      = 1'b1;
                    u_raddr   = IX_W'(ptr_reg);
                    didx_next = IX_W'(ptr_reg);
                    dv_next   = 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                end
                if (dv_reg)
                begin
                    if (didx_reg == pos_reg)
                    begin
                        rel_start_next = ur_start;
                        rel_size_next  = ur_size;
                    end
                    else
                    begin
                        u_we    = 1'b1;
                        u_waddr = didx_reg - 1'b1;
                        u_wdata = u_rdata;
                    end
                end
                else if (ptr_reg >= uc_reg)
                begin
                    uc_next       = uc_reg - 1'b1;
                    ptr_next      = '0;
                    prev_vld_next = 1'b0;
                    state_next    = fca_pkg::S_FIND;
                end
            end

            // First free entry at or above the released start
            fca_pkg::S_FIND:
            begin
                if (ptr_reg < fc_reg)
                begin
                    f_re      = 1'b1;
                    f_raddr   = IX_W'(ptr_reg);
                    didx_next = IX_W'(ptr_reg);
                    dv_next   = 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                end
                if (dv_reg)
                begin
                    if (fr_start < rel_start_reg)
                    begin
                        prev_vld_next   = 1'b1;
                        prev_start_next = fr_start;
                        prev_size_next  = fr_size;
                    end
                    else
                    begin
                        p_next         = CN_W'(didx_reg);
                        cur_vld_next   = 1'b1;
                        cur_start_next = fr_start;
                        cur_size_next  = fr_size;
                        state_next     = fca_pkg::S_MERGE;
                    end
                end
                else if (ptr_reg >= fc_reg)
                begin
                    p_next       = fc_reg;
                    cur_vld_next = 1'b0;
                    state_next   = fca_pkg::S_MERGE;
                end
            end

            fca_pkg::S_MERGE:
            begin
                res_ok_next = 1'b1;
                state_next  = fca_pkg::S_DONE;
                if (left && right)
                begin
                    f_we       = 1'b1;
                    f_waddr    = IX_W'(p_reg - 1'b1);
                    f_wdata    = {prev_start_reg,
                                  prev_size_reg + rel_size_reg + cur_size_reg};
                    fc_next    = fc_reg - 1'b1;
                    ptr_next   = p_reg + 1'b1;
                    lim_next   = fc_reg;
                    state_next = fca_pkg::S_SHIFT_DN;
                end
                else if (left)
                begin
                    f_we    = 1'b1;
                    f_waddr = IX_W'(p_reg - 1'b1);
                    f_wdata = {prev_start_reg, prev_size_reg + rel_size_reg};
                end
                else if (right)
                begin
                    f_we    = 1'b1;
                    f_waddr = IX_W'(p_reg);
                    f_wdata = {rel_start_reg, cur_size_reg + rel_size_reg};
                end
                else if (fc_reg < MAXB)
                begin
                    ptr_next   = fc_reg;
                    state_next = fca_pkg::S_SHIFT_UP;
                end
            end

            // Open a slot at p: entry k-1 moves to k from the top down
            fca_pkg::S_SHIFT_UP:
            begin
                if (ptr_reg > p_reg)
                begin
                    f_re      = 1'b1;
                    f_raddr   = IX_W'(ptr_reg - 1'b1);
                    didx_next = IX_W'(ptr_reg - 1'b1);
                    dv_next   = 1'b1;
                    ptr_next  = ptr_reg - 1'b1;
                end
                if (dv_reg)
                begin
                    f_we    = 1'b1;
                    f_waddr = didx_reg + 1'b1;
                    f_wdata = fr;
                end
                else if (ptr_reg <= p_reg)
                begin
                    f_we       = 1'b1;
                    f_waddr    = IX_W'(p_reg);
                    f_wdata    = {rel_start_reg, rel_size_reg};
                    fc_next    = fc_reg + 1'b1;
                    state_next = fca_pkg::S_DONE;
                end
            end

            fca_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = res_ok_reg;
                    start_out_next = fca_pkg::START_W'(res_start_reg);
                    count_out_next = fca_pkg::COUNT_W'(uc_reg);
                    state_next     = fca_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = fca_pkg::S_IDLE;
            end
        endcase

        dflt_next    = f_re && (f_raddr == '0) && !e0_init_reg;
        e0_init_next = e0_init_reg | (f_we && (f_waddr == '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fca_pkg::S_IDLE;
            policy_reg     <= fca_pkg::FIT_FIRST;
            fc_reg         <= CN_W'(1);
            uc_reg         <= '0;
            nf_pos_reg     <= '0;
            nf_empty_reg   <= 1'b0;
            e0_init_reg    <= 1'b0;
            dflt_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            ptr_reg        <= '0;
            cnt_reg        <= '0;
            lim_reg        <= '0;
            dv_reg         <= 1'b0;
            found_reg      <= 1'b0;
            prev_vld_reg   <= 1'b0;
            cur_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            policy_reg     <= policy_next;
            fc_reg         <= fc_next;
            uc_reg         <= uc_next;
            nf_pos_reg     <= nf_pos_next;
            nf_empty_reg   <= nf_empty_next;
            e0_init_reg    <= e0_init_next;
            dflt_reg       <= dflt_next;
            out_valid_reg  <= out_valid_next;
            ptr_reg        <= ptr_next;
            cnt_reg        <= cnt_next;
            lim_reg        <= lim_next;
            dv_reg         <= dv_next;
            found_reg      <= found_next;
            prev_vld_reg   <= prev_vld_next;
            cur_vld_reg    <= cur_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        didx_reg       <= didx_next;
        req_reg        <= req_next;
        pos_reg        <= pos_next;
        pick_idx_reg   <= pick_idx_next;
        pick_start_reg <= pick_start_next;
        pick_size_reg  <= pick_size_next;
        rel_start_reg  <= rel_start_next;
        rel_size_reg   <= rel_size_next;
        prev_start_reg <= prev_start_next;
        prev_size_reg  <= prev_size_next;
        cur_start_reg  <= cur_start_next;
        cur_size_reg   <= cur_size_next;
        p_reg          <= p_next;
        res_ok_reg     <= res_ok_next;
        res_start_reg  <= res_start_next;
        ok_reg         <= ok_next;
        start_out_reg  <= start_out_next;
        count_out_reg  <= count_out_next;
    end

endmodule

>>> design/fca_checker.sv
// Port-level assertions for the contiguous fit allocator, bound to the top level.
// Depends on fca_pkg and contiguous_fit_allocator_core.
module fca_checker #(
    parameter int MAX_BLOCKS = 64
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          ok,
    input logic [fca_pkg::START_W-1:0]   block_start,
    input logic [fca_pkg::COUNT_W-1:0]   allocated_count
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ok) && $stable(block_start)
                                   && $stable(allocated_count))
        else $error("stalled result changed");

    // Failed transactions report start 0
    a_fail_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> block_start == '0)
        else $error("failed transaction with nonzero block_start");

    // Allocated count never exceeds the table
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(allocated_count) <= MAX_BLOCKS)
        else $error("allocated_count above table depth");

    // One transaction in flight: stall rises after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction accepted while busy");

endmodule

bind contiguous_fit_allocator_core fca_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_fca_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .ok              (ok),
    .block_start     (block_start),
    .allocated_count (allocated_count)
);

>>> dv/contiguous_fit_allocator_core_tb.sv
// Testbench for contiguous_fit_allocator_core: directed and random allocate and release
// traffic checked against an in-bench allocator predictor. Depends on fca_pkg and the RTL.
module contiguous_fit_allocator_core_tb;

    localparam int MEM_UNITS  = 1024;
    localparam int MAX_BLOCKS = 64;
    localparam int SETTLE     = 3 * MAX_BLOCKS + 16;
    localparam int LIMIT      = 2_000_000;

    typedef struct {
        logic                      mode;
        logic [fca_pkg::REQ_W-1:0] size;
        logic [fca_pkg::POS_W-1:0] pos;
    } alloc_req_t;

    typedef struct {
        logic                        ok;
        logic [fca_pkg::START_W-1:0] start;
        logic [fca_pkg::COUNT_W-1:0] count;
    } alloc_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [fca_pkg::POLICY_W-1:0] fit_policy = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic mode = 1'b0;
    logic [fca_pkg::REQ_W-1:0] alloc_units = '0;
    logic [fca_pkg::POS_W-1:0] release_position = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic ok;
    logic [fca_pkg::START_W-1:0] block_start;
    logic [fca_pkg::COUNT_W-1:0] allocated_count;

    contiguous_fit_allocator_core #(
        .MEM_UNITS (MEM_UNITS),
        .MAX_BLOCKS(MAX_BLOCKS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .fit_policy      (fit_policy),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .alloc_units     (alloc_units),
        .release_position(release_position),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .ok              (ok),
        .block_start     (block_start),
        .allocated_count (allocated_count)
    );

    always #5 clk = ~clk;

    // Predictor state: free list in address order, granted blocks in allocation order
    int unsigned hole_base[$];
    int unsigned hole_len[$];
    int unsigned grant_base[$];
    int unsigned grant_len[$];
    int unsigned rover_pos;
    bit          rover_empty;
    fca_pkg::fit_policy_t policy_shadow;

    alloc_req_t  pending_reqs[$];
    alloc_rsp_t  expected_rsps[$];
    int          errors = 0;
    int          cycle_count = 0;
    int          hold_cycles = 0;

    // Carve req units from hole i; returns 1 when the hole is used up
    function automatic bit carve_hole(int unsigned i, int unsigned req,
                                      output int unsigned base);
        base = hole_base[i];
        grant_base.insert(grant_base.size(), hole_base[i]);
        grant_len.insert(grant_len.size(), req);
        if (hole_len[i] == req) begin
            hole_base.delete(i);
            hole_len.delete(i);
            return 1'b1;
        end
        hole_base[i] += req;
        hole_len[i]  -= req;
        return 1'b0;
    endfunction

    function automatic bit place_block(int unsigned req, output int unsigned base);
        int unsigned n;
        int unsigned first;
        int unsigned i;
        int pick;
        bit gone;
        base = 0;
        n = hole_base.size();
        if (req == 0 || grant_base.size() >= MAX_BLOCKS || n == 0)
            return 1'b0;
        if (policy_shadow == fca_pkg::FIT_NEXT) begin
            first = rover_empty ? 0 : rover_pos % n;
            for (int c = 0; c < n; c++) begin
                i = (first + c) % n;
                if (hole_len[i] >= req) begin
                    gone = carve_hole(i, req, base);
                    if (hole_base.size() == 0) begin
                        rover_empty = 1'b1;
                        rover_pos = 0;
                    end else begin
                        rover_empty = 1'b0;
                        rover_pos = (gone ? i : i + 1) % hole_base.size();
                    end
                    return 1'b1;
                end
            end
            return 1'b0;
        end
        pick = -1;
        for (int k = 0; k < n; k++) begin
            if (hole_len[k] < req && policy_shadow != fca_pkg::FIT_WORST)
                continue;
            if (pick < 0) begin
                pick = k;
                if (policy_shadow == fca_pkg::FIT_FIRST)
                    break;
            end else if (policy_shadow == fca_pkg::FIT_BEST
                         && hole_len[k] < hole_len[pick]) begin
                pick = k;
            end else if (policy_shadow == fca_pkg::FIT_WORST
                         && hole_len[k] > hole_len[pick]) begin
                pick = k;
            end
        end
        if (pick < 0 || hole_len[pick] < req)
            return 1'b0;
        void'(carve_hole(pick, req, base));
        return 1'b1;
    endfunction

    function automatic bit return_block(int unsigned pos);
        int unsigned s;
        int unsigned z;
        int unsigned p;
        bit left;
        bit right;
        if (pos >= grant_base.size())
            return 1'b0;
        s = grant_base[pos];
        z = grant_len[pos];
        grant_base.delete(pos);
        grant_len.delete(pos);
        p = 0;
        while (p < hole_base.size() && hole_base[p] < s)
            p++;
        left  = p > 0 && hole_base[p-1] + hole_len[p-1] == s;
        right = p < hole_base.size() && hole_base[p] == s + z;
        if (left && right) begin
            hole_len[p-1] += z + hole_len[p];
            hole_base.delete(p);
            hole_len.delete(p);
        end else if (left) begin
            hole_len[p-1] += z;
        end else if (right) begin
            hole_base[p] = s;
            hole_len[p] += z;
        end else if (hole_base.size() < MAX_BLOCKS) begin
            hole_base.insert(p, s);
            hole_len.insert(p, z);
        end
        return 1'b1;
    endfunction

    function automatic alloc_rsp_t predict_grant(alloc_req_t r);
        alloc_rsp_t e;
        int unsigned base;
        int unsigned live;
        base = 0;
        if (r.mode == fca_pkg::MODE_ALLOC) begin
            e.ok = place_block(r.size, base);
            if (!e.ok)
                base = 0;
        end else begin
            e.ok = return_block(r.pos);
        end
        live = grant_base.size();
        e.start = base[fca_pkg::START_W-1:0];
        e.count = live[fca_pkg::COUNT_W-1:0];
        return e;
    endfunction

    // Stall as seen at the rising edge, so the driver knows what was accepted
    logic in_stall_q = 1'b1;
    always @(posedge clk)
        in_stall_q <= in_stall;

    // Driver: one queued transaction at a time, with a random gap between them
    int gap = 0;
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall_q) begin
                // accepted at the last rising edge
                if (gap == 0 && pending_reqs.size() > 0) begin
                    {mode, alloc_units, release_position} <=
                        {pending_reqs[0].mode, pending_reqs[0].size, pending_reqs[0].pos};
                    expected_rsps.insert(expected_rsps.size(),
                                         predict_grant(pending_reqs.pop_front()));
                    gap = $urandom_range(0, 4);
                end else begin
                    in_valid <= 1'b0;
                end
            end else if (!in_valid && pending_reqs.size() > 0) begin
                if (gap > 0) begin
                    gap--;
                end else begin
                    in_valid <= 1'b1;
                    {mode, alloc_units, release_position} <=
                        {pending_reqs[0].mode, pending_reqs[0].size, pending_reqs[0].pos};
                    expected_rsps.insert(expected_rsps.size(),
                                         predict_grant(pending_reqs.pop_front()));
                    gap = $urandom_range(0, 4);
                end
            end
        end
    end

    // Receiver stall: a random stall after each accepted result, or a long hold-off counted here
    int rx_wait = 0;
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles--;
        end else if (rx_wait > 0) begin
            out_stall <= 1'b1;
            rx_wait--;
        end else begin
            out_stall <= 1'b0;
            if (out_valid && !out_stall)
                rx_wait = $urandom_range(0, 4);
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_rsps.size() == 0) begin
                $error("unexpected result ok=%0d block_start=%0d", ok, block_start);
                errors++;
            end else begin
                alloc_rsp_t e;
                e = expected_rsps.pop_front();
                if (ok !== e.ok) begin
                    $error("ok: expected %0d actual %0d", e.ok, ok);
                    errors++;
                end
                if (block_start !== e.start) begin
                    $error("block_start: expected %0d actual %0d", e.start, block_start);
                    errors++;
                end
                if (allocated_count !== e.count) begin
                    $error("allocated_count: expected %0d actual %0d", e.count,
                           allocated_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (cycle_count >= LIMIT) begin
            $display("contiguous_fit_allocator_core verification failed");
            $finish;
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || in_valid)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_policy(fca_pkg::fit_policy_t p);
        @(negedge clk);
        cfg_valid  <= 1'b1;
        fit_policy <= p;
        do @(posedge clk); while (!cfg_ready);
        policy_shadow = p;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_req(int unsigned m, int unsigned sz, int unsigned ps);
        alloc_req_t r;
        r.mode = m[0];
        r.size = sz[fca_pkg::REQ_W-1:0];
        r.pos  = ps[fca_pkg::POS_W-1:0];
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // Mostly well-formed traffic: sizes that fit, releases of live blocks
    task automatic random_burst(int count);
        int unsigned live;
        live = grant_base.size();
        for (int i = 0; i < count; i++) begin
            int sel;
            sel = $urandom_range(0, 99);
            if (sel < 50 && live < MAX_BLOCKS) begin
                queue_req(fca_pkg::MODE_ALLOC,
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(1, 40), $urandom);
                live++;
            end else if (sel < 92 && live > 0) begin
                queue_req(fca_pkg::MODE_RELEASE, $urandom, $urandom_range(0, live - 1));
                live--;
            end else begin
                queue_req($urandom_range(0, 1), $urandom, $urandom);
            end
        end
    endtask

    initial begin
        hole_base = '{0};
        hole_len = '{MEM_UNITS};
        rover_pos = 0;
        rover_empty = 1'b0;
        policy_shadow = fca_pkg::FIT_FIRST;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_policy(fca_pkg::FIT_FIRST);
        // Directed: zero size, oversize, exact fit of whole memory, bad position
        queue_req(fca_pkg::MODE_ALLOC, 0, 0);
        queue_req(fca_pkg::MODE_ALLOC, 2047, 63);
        queue_req(fca_pkg::MODE_ALLOC, 1024, 0);
        queue_req(fca_pkg::MODE_ALLOC, 1, 0);
        queue_req(fca_pkg::MODE_RELEASE, 0, 0);
        queue_req(fca_pkg::MODE_RELEASE, 0, 63);
        // Holes separated by live blocks, then merges on left, right and both sides
        for (int i = 0; i < 6; i++)
            queue_req(fca_pkg::MODE_ALLOC, 10 + i, 0);
        queue_req(fca_pkg::MODE_RELEASE, 0, 1);
        queue_req(fca_pkg::MODE_RELEASE, 0, 2);
        queue_req(fca_pkg::MODE_RELEASE, 0, 1);
        queue_req(fca_pkg::MODE_RELEASE, 0, 0);
        queue_req(fca_pkg::MODE_RELEASE, 0, 0);
        queue_req(fca_pkg::MODE_RELEASE, 0, 0);
        drain();

        // Fill the allocated table to hit the full-table failure
        for (int i = 0; i < MAX_BLOCKS + 1; i++)
            queue_req(fca_pkg::MODE_ALLOC, 1, 0);
        queue_req(fca_pkg::MODE_RELEASE, 0, 63);
        queue_req(fca_pkg::MODE_RELEASE, 0, 63);
        drain();

        // Long receiver hold-off while the sender keeps offering transactions
        hold_cycles = 600;
        random_burst(30);
        wait (hold_cycles == 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            set_policy(fca_pkg::fit_policy_t'(ph % 4));
            random_burst(190);
            drain();
        end
        set_policy(fca_pkg::FIT_WORST);
        random_burst(40);
        drain();

        if (errors == 0)
            $display("contiguous_fit_allocator_core verification clean");
        else
            $display("contiguous_fit_allocator_core verification failed");
        $finish;
    end
endmodule
